[src/vst_pkg.sv]
// ----------------------------------------------------------------------------
// vst_pkg
// Shared types, widths and codes of the tangent-driven vertex splitter.
// ----------------------------------------------------------------------------
package vst_pkg;

    // Field widths of the input and result words
    localparam int KIND_W   = 1;
    localparam int SRC_W    = 12;
    localparam int FLOAT_W  = 32;
    localparam int DEST_W   = 14;
    localparam int STATUS_W = 2;
    localparam int VCOUNT_W = 13;

    // Default sizes of the stores
    localparam int DEF_MAX_SOURCE_VERTICES = 4096;
    localparam int DEF_MAX_VARIANTS        = 16384;
    localparam int DEF_MAX_OUT_VERTICES    = 16384;

    // Chain-head epoch tag; tag value zero marks an empty head
    localparam int EPOCH_W = 4;
    localparam logic [EPOCH_W-1:0] EPOCH_EMPTY = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_CORNER = 1'b0;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Tangent key as stored in the variant memory and compared
    typedef struct packed {
        logic               negative;
        logic [FLOAT_W-1:0] z;
        logic [FLOAT_W-1:0] y;
        logic [FLOAT_W-1:0] x;
    } t_tangent;

endpackage

[src/vst_if.sv]
// ----------------------------------------------------------------------------
// vst_if
// Valid/ready channels of the splitter: corner words in, result words out.
// ----------------------------------------------------------------------------
interface vst_corner_if;
    logic                             valid;
    logic                             ready;
    logic [vst_pkg::KIND_W-1:0]       kind;
    logic [vst_pkg::SRC_W-1:0]        source_vertex;
    logic [vst_pkg::FLOAT_W-1:0]      tangent_x;
    logic [vst_pkg::FLOAT_W-1:0]      tangent_y;
    logic [vst_pkg::FLOAT_W-1:0]      tangent_z;
    logic                             tangent_negative;

    modport source (output valid, kind, source_vertex, tangent_x, tangent_y,
                    tangent_z, tangent_negative, input ready);
    modport sink   (input valid, kind, source_vertex, tangent_x, tangent_y,
                    tangent_z, tangent_negative, output ready);
endinterface

interface vst_result_if;
    logic                             valid;
    logic                             ready;
    logic [vst_pkg::DEST_W-1:0]       dest_vertex;
    logic                             first_variant;
    logic                             new_copy;
    logic [vst_pkg::STATUS_W-1:0]     status;

    modport source (output valid, dest_vertex, first_variant, new_copy, status,
                    input ready);
    modport sink   (input valid, dest_vertex, first_variant, new_copy, status,
                    output ready);
endinterface

[src/vst_ram.sv]
// ----------------------------------------------------------------------------
// vst_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module vst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read data registered; a write returns the old word at that address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

[src/vst_match.sv]
// ----------------------------------------------------------------------------
// vst_match
// Tangent compare unit: float equality on x, y, z plus sign equality.
// ----------------------------------------------------------------------------
module vst_match (
    input  vst_pkg::t_tangent i_key,
    input  vst_pkg::t_tangent i_stored,
    output logic              o_match
);

    // NaN: exponent all ones with a nonzero mantissa
    function automatic logic is_nan(input logic [vst_pkg::FLOAT_W-1:0] v);
        is_nan = (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
    endfunction

    // Float equality; +0 and -0 are equal, NaN equals nothing
    function automatic logic float_eq(input logic [vst_pkg::FLOAT_W-1:0] a,
                                      input logic [vst_pkg::FLOAT_W-1:0] b);
        logic both_zero;
        both_zero = ((a[30:0] | b[30:0]) == 31'd0);
        float_eq  = !is_nan(a) && !is_nan(b) && (both_zero || (a == b));
    endfunction

    assign o_match = float_eq(i_key.x, i_stored.x)
                  && float_eq(i_key.y, i_stored.y)
                  && float_eq(i_key.z, i_stored.z)
                  && (i_key.negative == i_stored.negative);

endmodule

[src/vertex_split_by_tangent_core.sv]
// ----------------------------------------------------------------------------
// vertex_split_by_tangent_core
// Tangent-driven vertex splitter: per-vertex chains of tangent variants.
// ----------------------------------------------------------------------------
// A corner word that allocates a variant passes through these steps in order:
// take the word, read the chain head, read one chain entry at a time from
// the single-port variant memory (the walk), allocate, and hand the result
// to the output register. A corner that matches an entry skips the allocate
// step. Clear words and out-of-range corners go straight from taking the
// word to handing the result over. The output register lets a result wait
// while the next word is taken; the hand-over of a new result waits while
// the previous result still sits unread in the output register. After reset,
// and after every fifteenth clear word, the chain-head memory is swept once,
// all MAX_SOURCE_VERTICES heads (4096 by default), with no word accepted; the
// other clears retire all chains at once by advancing a 4-bit epoch tag.
// vertex_count is written through i_cfg_we / i_cfg_wdata; the user must do
// so only while the block is idle, and the block itself does not enforce it.
module vertex_split_by_tangent_core #(
    parameter int MAX_SOURCE_VERTICES = vst_pkg::DEF_MAX_SOURCE_VERTICES,
    parameter int MAX_VARIANTS        = vst_pkg::DEF_MAX_VARIANTS,
    parameter int MAX_OUT_VERTICES    = vst_pkg::DEF_MAX_OUT_VERTICES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vst_pkg::VCOUNT_W-1:0]   i_cfg_wdata,
    vst_corner_if.sink                     i_corner,
    vst_result_if.source                   o_result
);

    // Widths derived from the store sizes
    localparam int SAW  = (MAX_SOURCE_VERTICES > 1) ? $clog2(MAX_SOURCE_VERTICES) : 1;
    localparam int VAW  = (MAX_VARIANTS > 1) ? $clog2(MAX_VARIANTS) : 1;
    localparam int UW   = $clog2(MAX_VARIANTS + 1);
    localparam int OW   = $clog2(MAX_OUT_VERTICES + 1);
    localparam int TW   = (OW > vst_pkg::VCOUNT_W) ? OW : vst_pkg::VCOUNT_W;
    localparam int KEYW = $bits(vst_pkg::t_tangent);
    localparam int HW   = vst_pkg::EPOCH_W + VAW;
    localparam int VW   = 1 + VAW + vst_pkg::DEST_W + KEYW;

    // Variant entry layout: {next_valid, next, dest, key}
    localparam int V_KEY_LO  = 0;
    localparam int V_DEST_LO = KEYW;
    localparam int V_NEXT_LO = KEYW + vst_pkg::DEST_W;
    localparam int V_NV_BIT  = KEYW + vst_pkg::DEST_W + VAW;

    localparam logic [SAW-1:0] CLR_LAST = SAW'(MAX_SOURCE_VERTICES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_ALLOC,
        S_DONE
    } t_state;

    t_state                         r_state, n_state;
    vst_pkg::t_tangent              r_key, n_key;
    logic [vst_pkg::SRC_W-1:0]      r_src, n_src;
    logic                           r_have0, n_have0;
    logic [VAW-1:0]                 r_head0, n_head0;
    logic [UW-1:0]                  r_used, n_used;
    logic [TW-1:0]                  r_total, n_total;
    logic [vst_pkg::EPOCH_W-1:0]    r_epoch, n_epoch;
    logic [vst_pkg::VCOUNT_W-1:0]   r_vc;
    logic                           r_pass, n_pass;
    logic [SAW-1:0]                 r_clr_addr, n_clr_addr;
    logic [vst_pkg::DEST_W-1:0]     r_res_dest, n_res_dest;
    logic                           r_res_first, n_res_first;
    logic                           r_res_copy, n_res_copy;
    vst_pkg::t_status               r_res_status, n_res_status;
    logic                           r_out_valid, n_out_valid;
    logic [vst_pkg::DEST_W-1:0]     r_out_dest, n_out_dest;
    logic                           r_out_first, n_out_first;
    logic                           r_out_copy, n_out_copy;
    vst_pkg::t_status               r_out_status, n_out_status;

    logic                           head_we;
    logic [SAW-1:0]                 head_addr;
    logic [HW-1:0]                  head_wdata, head_rdata;
    logic                           var_we;
    logic [VAW-1:0]                 var_addr;
    logic [VW-1:0]                  var_wdata, var_rdata;

    vst_pkg::t_tangent              in_key, var_key;
    logic                           var_match;
    logic                           accept;
    logic                           src_bad;
    logic [vst_pkg::EPOCH_W-1:0]    head_tag;
    logic [VAW-1:0]                 head_idx;
    logic                           head_have;
    logic                           var_nv;
    logic [VAW-1:0]                 var_next;
    logic [vst_pkg::DEST_W-1:0]     var_dest;
    logic [TW-1:0]                  base;

    // Chain heads: {epoch tag, first variant index}
    vst_ram #(.WIDTH(HW), .DEPTH(MAX_SOURCE_VERTICES)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_addr  (head_addr),
        .i_wdata (head_wdata),
        .o_rdata (head_rdata)
    );

    // Variant store
    vst_ram #(.WIDTH(VW), .DEPTH(MAX_VARIANTS)) u_var_ram (
        .i_clk   (i_clk),
        .i_we    (var_we),
        .i_addr  (var_addr),
        .i_wdata (var_wdata),
        .o_rdata (var_rdata)
    );

    // Shared tangent compare
    vst_match u_match (
        .i_key    (r_key),
        .i_stored (var_key),
        .o_match  (var_match)
    );

    // Field split of the memory read words
    assign head_tag  = head_rdata[HW-1 -: vst_pkg::EPOCH_W];
    assign head_idx  = head_rdata[VAW-1:0];
    assign head_have = (head_tag == r_epoch);
    assign var_key   = var_rdata[V_KEY_LO +: KEYW];
    assign var_dest  = var_rdata[V_DEST_LO +: vst_pkg::DEST_W];
    assign var_next  = var_rdata[V_NEXT_LO +: VAW];
    assign var_nv    = var_rdata[V_NV_BIT];

    // Incoming word
    assign in_key.negative = i_corner.tangent_negative;
    assign in_key.z        = i_corner.tangent_z;
    assign in_key.y        = i_corner.tangent_y;
    assign in_key.x        = i_corner.tangent_x;
    assign i_corner.ready  = (r_state == S_IDLE);
    assign accept          = i_corner.valid && i_corner.ready;
    assign src_bad = ({1'b0, i_corner.source_vertex} >= r_vc)
                  || (32'(i_corner.source_vertex) >= 32'(MAX_SOURCE_VERTICES));

    // Copy numbering starts at vertex_count at the least
    assign base = (r_total < TW'(r_vc)) ? TW'(r_vc) : r_total;

    // Result channel
    assign o_result.valid         = r_out_valid;
    assign o_result.dest_vertex   = r_out_dest;
    assign o_result.first_variant = r_out_first;
    assign o_result.new_copy      = r_out_copy;
    assign o_result.status        = r_out_status;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_src        = r_src;
        n_have0      = r_have0;
        n_head0      = r_head0;
        n_used       = r_used;
        n_total      = r_total;
        n_epoch      = r_epoch;
        n_pass       = r_pass;
        n_clr_addr   = r_clr_addr;
        n_res_dest   = r_res_dest;
        n_res_first  = r_res_first;
        n_res_copy   = r_res_copy;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out_dest   = r_out_dest;
        n_out_first  = r_out_first;
        n_out_copy   = r_out_copy;
        n_out_status = r_out_status;

        head_we    = 1'b0;
        head_addr  = SAW'(i_corner.source_vertex);
        head_wdata = {r_epoch, VAW'(r_used)};
        var_we     = 1'b0;
        var_addr   = VAW'(r_used);
        var_wdata  = {r_have0, r_head0, r_res_dest, r_key};

        case (r_state)
            // Sweep every chain head to empty
            S_CLEAR: begin
                head_we    = 1'b1;
                head_addr  = r_clr_addr;
                head_wdata = {vst_pkg::EPOCH_EMPTY, VAW'(0)};
                n_clr_addr = r_clr_addr + SAW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end

            // Take a word; head read is issued at the corner's index
            S_IDLE: begin
                if (accept) begin
                    n_key        = in_key;
                    n_src        = i_corner.source_vertex;
                    n_res_dest   = '0;
                    n_res_first  = 1'b0;
                    n_res_copy   = 1'b0;
                    n_res_status = vst_pkg::STATUS_OK;
                    if (i_corner.kind == vst_pkg::KIND_CLEAR) begin
                        n_used  = '0;
                        n_total = TW'(r_vc);
                        if (r_epoch == vst_pkg::EPOCH_LAST) begin
                            n_epoch = vst_pkg::EPOCH_FIRST;
                            n_pass  = 1'b1;
                        end else begin
                            n_epoch = r_epoch + vst_pkg::EPOCH_W'(1);
                        end
                        n_state = S_DONE;
                    end else if (src_bad) begin
                        n_res_status = vst_pkg::STATUS_RANGE;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_HEAD;
                    end
                end
            end

            // Head word is in; start the walk at the first variant, or allocate if the chain is empty
            S_HEAD: begin
                n_have0  = head_have;
                n_head0  = head_idx;
                var_addr = head_idx;
                if (head_have && (UW'(head_idx) < r_used)) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_ALLOC;
                end
            end

            // One variant per cycle
            S_WALK: begin
                var_addr = var_next;
                if (var_match) begin
                    n_res_dest = var_dest;
                    n_state    = S_DONE;
                end else if (!(var_nv && (UW'(var_next) < r_used))) begin
                    n_state = S_ALLOC;
                end
            end

            // Allocate a variant, in place or as a new copy, or report STATUS_FULL
            S_ALLOC: begin
                head_addr = SAW'(r_src);
                n_state   = S_DONE;
                if (r_used >= UW'(MAX_VARIANTS)) begin
                    n_res_status = vst_pkg::STATUS_FULL;
                end else if (!r_have0) begin
                    n_res_dest  = vst_pkg::DEST_W'(r_src);
                    n_res_first = 1'b1;
                    var_wdata   = {r_have0, r_head0, vst_pkg::DEST_W'(r_src), r_key};
                    var_we      = 1'b1;
                    head_we     = 1'b1;
                    n_used      = r_used + UW'(1);
                end else if (base >= TW'(MAX_OUT_VERTICES)) begin
                    n_res_status = vst_pkg::STATUS_FULL;
                end else begin
                    n_res_dest = vst_pkg::DEST_W'(base);
                    n_res_copy = 1'b1;
                    var_wdata  = {r_have0, r_head0, vst_pkg::DEST_W'(base), r_key};
                    var_we     = 1'b1;
                    head_we    = 1'b1;
                    n_used     = r_used + UW'(1);
                    n_total    = base + TW'(1);
                end
            end

            // Hand the result to the output register, then return to idle or, after the epoch wraps, sweep the heads
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_dest   = r_res_dest;
                    n_out_first  = r_res_first;
                    n_out_copy   = r_res_copy;
                    n_out_status = r_res_status;
                    n_pass       = 1'b0;
                    n_clr_addr   = '0;
                    n_state      = r_pass ? S_CLEAR : S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_used      <= '0;
            r_total     <= '0;
            r_epoch     <= vst_pkg::EPOCH_FIRST;
            r_vc        <= vst_pkg::VCOUNT_W'(1);
            r_pass      <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_total     <= n_total;
            r_epoch     <= n_epoch;
            r_pass      <= n_pass;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_vc <= i_cfg_wdata;
            end
        end
        r_key        <= n_key;
        r_src        <= n_src;
        r_have0      <= n_have0;
        r_head0      <= n_head0;
        r_res_dest   <= n_res_dest;
        r_res_first  <= n_res_first;
        r_res_copy   <= n_res_copy;
        r_res_status <= n_res_status;
        r_out_dest   <= n_out_dest;
        r_out_first  <= n_out_first;
        r_out_copy   <= n_out_copy;
        r_out_status <= n_out_status;
    end

endmodule
